// File: hw/rtl/fbt_pkg.sv
// Shared types and constants for the frame budget throttle.
package fbt_pkg;

  localparam int CMD_W   = 3;
  localparam int FIELD_W = 16;
  localparam int MAX_W   = 5;
  localparam int BUD_W   = 6;
  localparam int KIND_W  = 3;
  localparam int REM_W   = 7;

  localparam logic [FIELD_W-1:0] FAST_LIMIT   = 16'd2048;
  localparam logic [FIELD_W-1:0] SLOW_LIMIT   = 16'd4096;
  localparam logic [BUD_W-1:0]   BUDGET_FLOOR = 6'd2;
  localparam logic [MAX_W-1:0]   MAX_RESET    = 5'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACTIVATE = 3'd0,
    CMD_CREATE   = 3'd1,
    CMD_POPULATE = 3'd2,
    CMD_FRAME    = 3'd3,
    CMD_FTIME    = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RUN_NOW   = 3'd0,
    KIND_BACKLOG   = 3'd1,
    KIND_QUEUED    = 3'd2,
    KIND_DROPPED   = 3'd3,
    KIND_POP_ALLOW = 3'd4,
    KIND_POP_SKIP  = 3'd5,
    KIND_SUMMARY   = 3'd6
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] request_id;
    logic [FIELD_W-1:0] frame_time;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] group_id;
    logic [BUD_W-1:0]   drained;
    logic [REM_W-1:0]   remaining;
    logic               last;
  } res_t;

endpackage

// File: hw/rtl/fbt_fifo.sv
// Small first-in first-out queue of flat words.
module fbt_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// File: hw/rtl/fbt_front.sv
// Front end: accepts input transactions, drops unknown commands, queues the rest.
module fbt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [fbt_pkg::CMD_W-1:0]   command,
  input  logic [fbt_pkg::FIELD_W-1:0] request_id,
  input  logic [fbt_pkg::FIELD_W-1:0] frame_time,
  output logic                        cmd_valid,
  output fbt_pkg::cmd_t               cmd,
  input  logic                        cmd_pop
);

  fbt_pkg::cmd_t                  cmd_in;
  logic                           known;
  logic                           cmd_empty;
  logic [$bits(fbt_pkg::cmd_t)-1:0] cmd_word;

  always_comb begin
    cmd_in.op         = fbt_pkg::op_t'(command);
    cmd_in.request_id = request_id;
    cmd_in.frame_time = frame_time;
    case (command)
      fbt_pkg::CMD_ACTIVATE,
      fbt_pkg::CMD_CREATE,
      fbt_pkg::CMD_POPULATE,
      fbt_pkg::CMD_FRAME,
      fbt_pkg::CMD_FTIME: known = 1'b1;
      default:            known = 1'b0;
    endcase
  end

  fbt_fifo #(
    .WIDTH($bits(fbt_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && known),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd_word),
    .empty(cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd       = fbt_pkg::cmd_t'(cmd_word);

endmodule

// File: hw/rtl/fbt_back.sv
// Back end: budget, counters, backlog memory and the frame drain sequencer.
module fbt_back #(
  parameter int BACKLOG_DEPTH = 64,
  parameter int ID_WIDTH      = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  fbt_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output fbt_pkg::res_t             res,
  input  logic                      cfg_we,
  input  logic [fbt_pkg::MAX_W-1:0] cfg_data
);

  localparam int AW     = $clog2(BACKLOG_DEPTH);
  localparam int CNT_W  = $clog2(BACKLOG_DEPTH + 1);
  localparam int KEEP_W = (ID_WIDTH < fbt_pkg::FIELD_W) ? ID_WIDTH : fbt_pkg::FIELD_W;

  fbt_pkg::state_t              state, state_next;
  logic [fbt_pkg::MAX_W-1:0]    max_per_frame, max_per_frame_next;
  logic [AW-1:0]                head, head_next;
  logic [CNT_W-1:0]             count, count_next;
  logic [fbt_pkg::BUD_W-1:0]    activated, activated_next;
  logic [fbt_pkg::FIELD_W-1:0]  created, created_next;
  logic [fbt_pkg::FIELD_W-1:0]  last_frame_time, last_frame_time_next;
  logic [fbt_pkg::BUD_W-1:0]    drained, drained_next;

  logic [KEEP_W-1:0]            backlog [BACKLOG_DEPTH];
  logic [KEEP_W-1:0]            rd_data;
  logic [KEEP_W-1:0]            wr_id;
  logic                         wr_en;
  logic [CNT_W:0]               tail_sum;
  logic [AW-1:0]                tail;
  logic [AW-1:0]                head_inc;
  logic [fbt_pkg::BUD_W-1:0]    scaled;
  logic [fbt_pkg::BUD_W-1:0]    budget;

  always_comb begin
    if (last_frame_time < fbt_pkg::FAST_LIMIT) begin
      scaled = {max_per_frame, 1'b0};
    end else if (last_frame_time > fbt_pkg::SLOW_LIMIT) begin
      scaled = fbt_pkg::BUD_W'(max_per_frame >> 1);
    end else begin
      scaled = fbt_pkg::BUD_W'(max_per_frame);
    end
    budget = (scaled < fbt_pkg::BUDGET_FLOOR) ? fbt_pkg::BUDGET_FLOOR : scaled;
  end

  assign wr_id    = cmd.request_id[KEEP_W-1:0];
  assign tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign tail     = (tail_sum >= (CNT_W+1)'(BACKLOG_DEPTH))
                    ? AW'(tail_sum - (CNT_W+1)'(BACKLOG_DEPTH)) : AW'(tail_sum);
  assign head_inc = (head == AW'(BACKLOG_DEPTH - 1)) ? '0 : head + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fbt_pkg::ST_IDLE;
      max_per_frame   <= fbt_pkg::MAX_RESET;
      head            <= '0;
      count           <= '0;
      activated       <= '0;
      created         <= '0;
      last_frame_time <= '0;
      drained         <= '0;
    end else begin
      state           <= state_next;
      max_per_frame   <= max_per_frame_next;
      head            <= head_next;
      count           <= count_next;
      activated       <= activated_next;
      created         <= created_next;
      last_frame_time <= last_frame_time_next;
      drained         <= drained_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      backlog[tail] <= wr_id;
    end
    if (wr_en && (tail == head_next)) begin
      rd_data <= wr_id;
    end else begin
      rd_data <= backlog[head_next];
    end
  end

  always_comb begin
    state_next           = state;
    max_per_frame_next   = cfg_we ? cfg_data : max_per_frame;
    head_next            = head;
    count_next           = count;
    activated_next       = activated;
    created_next         = created;
    last_frame_time_next = last_frame_time;
    drained_next         = drained;
    cmd_pop              = 1'b0;
    res_push             = 1'b0;
    wr_en                = 1'b0;
    res.kind             = fbt_pkg::KIND_RUN_NOW;
    res.group_id         = '0;
    res.drained          = '0;
    res.remaining        = fbt_pkg::REM_W'(count);
    res.last             = 1'b1;
    case (state)
      fbt_pkg::ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            fbt_pkg::CMD_ACTIVATE: begin
              res_push     = 1'b1;
              res.group_id = fbt_pkg::FIELD_W'(wr_id);
              if (activated < budget) begin
                activated_next = activated + 1'b1;
                res.kind       = fbt_pkg::KIND_RUN_NOW;
              end else if (count != CNT_W'(BACKLOG_DEPTH)) begin
                wr_en         = 1'b1;
                count_next    = count + 1'b1;
                res.kind      = fbt_pkg::KIND_QUEUED;
                res.remaining = fbt_pkg::REM_W'(count_next);
              end else begin
                res.kind = fbt_pkg::KIND_DROPPED;
              end
            end
            fbt_pkg::CMD_CREATE: begin
              if (created != '1) begin
                created_next = created + 1'b1;
              end
            end
            fbt_pkg::CMD_POPULATE: begin
              res_push = 1'b1;
              res.kind = (created > fbt_pkg::FIELD_W'(max_per_frame))
                         ? fbt_pkg::KIND_POP_SKIP : fbt_pkg::KIND_POP_ALLOW;
            end
            fbt_pkg::CMD_FRAME: begin
              activated_next = '0;
              created_next   = '0;
              drained_next   = '0;
              state_next     = fbt_pkg::ST_DRAIN;
            end
            fbt_pkg::CMD_FTIME: begin
              last_frame_time_next = cmd.frame_time;
            end
            default: begin
            end
          endcase
        end
      end
      fbt_pkg::ST_DRAIN: begin
        if (!res_full) begin
          res_push = 1'b1;
          if ((count != '0) && (drained < budget)) begin
            head_next      = head_inc;
            count_next     = count - 1'b1;
            activated_next = activated + 1'b1;
            drained_next   = drained + 1'b1;
            res.kind       = fbt_pkg::KIND_BACKLOG;
            res.group_id   = fbt_pkg::FIELD_W'(rd_data);
            res.remaining  = fbt_pkg::REM_W'(count_next);
            res.last       = 1'b0;
          end else begin
            res.kind    = fbt_pkg::KIND_SUMMARY;
            res.drained = drained;
            state_next  = fbt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = fbt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/frame_budget_throttle_with_backlog.sv
// Top level of the frame budget throttle with its deferral backlog.
// Commands pass through a registered command queue and results through a result queue.
// Throughput: one input per cycle for requests and updates while full is low; a frame
// start holds the back end in its drain state, one backlog memory read per drained entry.
// Reset: rst clears counters, pointers, queues and the budget register (to 4);
// the backlog memory is not cleared, and no clearing pass runs.
module frame_budget_throttle_with_backlog #(
  parameter int BACKLOG_DEPTH = 64,
  parameter int ID_WIDTH      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [fbt_pkg::CMD_W-1:0]   command,
  input  logic [fbt_pkg::FIELD_W-1:0] request_id,
  input  logic [fbt_pkg::FIELD_W-1:0] frame_time,
  output logic                        empty,
  input  logic                        pop,
  output logic [fbt_pkg::KIND_W-1:0]  kind,
  output logic [fbt_pkg::FIELD_W-1:0] group_id,
  output logic [fbt_pkg::BUD_W-1:0]   drained,
  output logic [fbt_pkg::REM_W-1:0]   remaining,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbt_pkg::MAX_W-1:0]   cfg_data
);

  logic                             cmd_valid;
  fbt_pkg::cmd_t                    cmd;
  logic                             cmd_pop;
  logic                             res_full;
  logic                             res_push;
  fbt_pkg::res_t                    res;
  logic [$bits(fbt_pkg::res_t)-1:0] res_word;
  fbt_pkg::res_t                    res_out;

  assign cfg_ready = 1'b1;

  fbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .request_id(request_id),
    .frame_time(frame_time),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fbt_back #(
    .BACKLOG_DEPTH(BACKLOG_DEPTH),
    .ID_WIDTH     (ID_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

  fbt_fifo #(
    .WIDTH($bits(fbt_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (res_word),
    .empty(empty)
  );

  assign res_out   = fbt_pkg::res_t'(res_word);
  assign kind      = res_out.kind;
  assign group_id  = res_out.group_id;
  assign drained   = res_out.drained;
  assign remaining = res_out.remaining;
  assign last      = res_out.last;

endmodule

// File: verif/fbt_tb_pkg.sv
// Scoreboard class for the frame budget throttle: throttle decision predictor and checker.
package fbt_tb_pkg;
  import fbt_pkg::*;

  class throttle_scoreboard;
    localparam int BACKLOG_SLOTS = 64;

    logic [MAX_W-1:0]   base_max;
    logic [FIELD_W-1:0] deferred_ids [BACKLOG_SLOTS];
    logic [5:0]         head;
    logic [REM_W-1:0]   waiting;
    logic [6:0]         activated;
    logic [FIELD_W-1:0] created;
    logic [FIELD_W-1:0] last_ft;
    res_t               decisions_due [$];
    int                 failures;
    int                 checked;

    function new();
      base_max  = MAX_RESET;
      head      = '0;
      waiting   = '0;
      activated = '0;
      created   = '0;
      last_ft   = '0;
      failures  = 0;
      checked   = 0;
    endfunction

    function void set_base(logic [MAX_W-1:0] v);
      base_max = v;
    endfunction

    function logic [BUD_W-1:0] budget();
      logic [BUD_W-1:0] b;
      b = {1'b0, base_max};
      if (last_ft < FAST_LIMIT) begin
        b = {base_max, 1'b0};
      end else if (last_ft > SLOW_LIMIT) begin
        b = {2'b00, base_max[MAX_W-1:1]};
      end
      if (b < BUDGET_FLOOR) begin
        b = BUDGET_FLOOR;
      end
      return b;
    endfunction

    function void add_decision(kind_t k, logic [FIELD_W-1:0] g, logic [BUD_W-1:0] d,
                               logic l);
      res_t r;
      r.kind      = k;
      r.group_id  = g;
      r.drained   = d;
      r.remaining = waiting;
      r.last      = l;
      decisions_due.insert(decisions_due.size(), r);
    endfunction

    // Advance the predicted throttle state by one accepted transaction.
    function void note_command(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] id,
                               logic [FIELD_W-1:0] ft);
      logic [BUD_W-1:0]   b;
      logic [BUD_W-1:0]   n;
      logic [5:0]         tail;
      logic [FIELD_W-1:0] g;
      case (cmd)
        CMD_ACTIVATE: begin
          b = budget();
          if (activated < b) begin
            activated++;
            add_decision(KIND_RUN_NOW, id, '0, 1'b1);
          end else if (waiting < BACKLOG_SLOTS) begin
            tail = head + waiting[5:0];
            deferred_ids[tail] = id;
            waiting++;
            add_decision(KIND_QUEUED, id, '0, 1'b1);
          end else begin
            add_decision(KIND_DROPPED, id, '0, 1'b1);
          end
        end
        CMD_CREATE: begin
          if (created != 16'hFFFF) begin
            created++;
          end
        end
        CMD_POPULATE: begin
          add_decision(created > base_max ? KIND_POP_SKIP : KIND_POP_ALLOW, '0, '0, 1'b1);
        end
        CMD_FRAME: begin
          activated = '0;
          created   = '0;
          b = budget();
          n = '0;
          while (waiting > 0 && n < b) begin
            g = deferred_ids[head];
            head++;
            waiting--;
            activated++;
            add_decision(KIND_BACKLOG, g, '0, 1'b0);
            n++;
          end
          add_decision(KIND_SUMMARY, '0, n, 1'b1);
        end
        CMD_FTIME: begin
          last_ft = ft;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (decisions_due.size() == 0) begin
        $error("unexpected result: kind %0d group_id %0h drained %0d remaining %0d last %0d",
               got.kind, got.group_id, got.drained, got.remaining, got.last);
        failures++;
        return;
      end
      want = decisions_due[0];
      decisions_due.delete(0);
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        failures++;
      end
      if (got.group_id !== want.group_id) begin
        $error("group_id: expected %0h, got %0h", want.group_id, got.group_id);
        failures++;
      end
      if (got.drained !== want.drained) begin
        $error("drained: expected %0d, got %0d", want.drained, got.drained);
        failures++;
      end
      if (got.remaining !== want.remaining) begin
        $error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        failures++;
      end
    endfunction

    function int outstanding();
      return decisions_due.size();
    endfunction
  endclass

endpackage

// File: verif/tb.sv
// Testbench top for the frame budget throttle: stimulus, handshakes and end-of-run verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbt_pkg::*;
  import fbt_tb_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  logic [CMD_W-1:0]   command;
  logic [FIELD_W-1:0] request_id;
  logic [FIELD_W-1:0] frame_time;
  logic               empty;
  logic               pop;
  logic [KIND_W-1:0]  kind;
  logic [FIELD_W-1:0] group_id;
  logic [BUD_W-1:0]   drained;
  logic [REM_W-1:0]   remaining;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [MAX_W-1:0]   cfg_data;

  throttle_scoreboard sb;
  bit                 no_idle;
  bit                 hold_request;
  int                 commands_sent;
  int                 cfg_writes;

  frame_budget_throttle_with_backlog uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .command(command), .request_id(request_id), .frame_time(frame_time),
    .empty(empty), .pop(pop),
    .kind(kind), .group_id(group_id), .drained(drained), .remaining(remaining),
    .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [FIELD_W-1:0] pick_frame_time();
    int r;
    r = $urandom_range(0, 6);
    case (r)
      0: return FIELD_W'($urandom_range(0, 2047));
      1: return FAST_LIMIT;
      2: return FIELD_W'($urandom_range(2049, 4095));
      3: return SLOW_LIMIT;
      4: return SLOW_LIMIT + 16'd1;
      5: return FIELD_W'($urandom_range(4097, 65535));
      default: return FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] id,
                           logic [FIELD_W-1:0] ft);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    command    <= cmd;
    request_id <= id;
    frame_time <= ft;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_command(cmd, id, ft);
    if (cmd <= CMD_FTIME) begin
      commands_sent++;
    end
  endtask

  task automatic send_mixed(int act_pct);
    int               r;
    logic [CMD_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < act_pct) begin
      c = CMD_ACTIVATE;
    end else begin
      r = $urandom_range(0, 19);
      if (r < 7) c = CMD_CREATE;
      else if (r < 13) c = CMD_POPULATE;
      else if (r < 16) c = CMD_FRAME;
      else if (r < 18) c = CMD_FTIME;
      else c = CMD_W'($urandom_range(5, 7));
    end
    send_item(c, FIELD_W'($urandom_range(0, 65535)), pick_frame_time());
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Hold off until idle, then write the budget base.
  task automatic write_base(logic [MAX_W-1:0] v);
    wait_all_results();
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_base(v);
    cfg_writes++;
  endtask

  initial begin
    int               n;
    int               phase;
    logic [MAX_W-1:0] v;
    sb = new();
    rst        <= 1'b1;
    push       <= 1'b0;
    command    <= '0;
    request_id <= '0;
    frame_time <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_base(5'd0);
    send_item(CMD_ACTIVATE, 16'h0000, 16'h0000);
    send_item(CMD_ACTIVATE, 16'hFFFF, 16'hFFFF);
    send_item(CMD_ACTIVATE, 16'h1234, 16'h0000);
    send_item(CMD_ACTIVATE, 16'hEDCB, 16'h0000);
    send_item(CMD_CREATE, 16'h0000, 16'h0000);
    send_item(CMD_POPULATE, 16'h0000, 16'h0000);
    send_item(3'd5, 16'hFFFF, 16'hFFFF);
    send_item(3'd6, 16'h0000, 16'h0000);
    send_item(3'd7, 16'hFFFF, 16'hFFFF);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FTIME, 16'h0000, 16'hFFFF);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    write_base(5'd31);
    send_item(CMD_FTIME, 16'h0000, FAST_LIMIT);
    send_item(CMD_POPULATE, 16'h0000, 16'h0000);
    send_item(CMD_FTIME, 16'h0000, SLOW_LIMIT);
    send_item(CMD_FTIME, 16'h0000, SLOW_LIMIT + 16'd1);
    send_item(CMD_FTIME, 16'h0000, FAST_LIMIT - 16'd1);
    send_item(CMD_ACTIVATE, FIELD_W'($urandom_range(0, 65535)), 16'h0000);
    send_item(CMD_FTIME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);

    // Flood the backlog while results are held off, then drain it at the widest budget.
    write_base(5'd31);
    send_item(CMD_FTIME, 16'h0000, FIELD_W'($urandom_range(4097, 65535)));
    hold_request = 1'b1;
    no_idle      = 1'b1;
    repeat (90) send_item(CMD_ACTIVATE, FIELD_W'($urandom_range(0, 65535)), 16'h0000);
    no_idle = 1'b0;
    send_item(CMD_FTIME, 16'h0000, FIELD_W'($urandom_range(0, 2047)));
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    send_item(CMD_FRAME, 16'h0000, 16'h0000);
    wait_all_results();

    phase = 0;
    while (commands_sent < 270) begin
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(0, 5);
        if (n == 0) v = 5'd0;
        else if (n == 1) v = 5'd31;
        else v = MAX_W'($urandom_range(0, 31));
        write_base(v);
      end
      if (phase == 3) begin
        wait_all_results();
      end
      no_idle = ($urandom_range(0, 3) == 0);
      send_item(CMD_FTIME, 16'h0000, pick_frame_time());
      n = $urandom_range(15, 40);
      if ($urandom_range(0, 2) == 0) begin
        repeat (n) send_mixed(85);
      end else begin
        repeat (n) send_mixed(45);
      end
      send_item(CMD_FRAME, 16'h0000, 16'h0000);
      phase++;
    end
    no_idle = 1'b0;

    wait_all_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d commands, %0d results checked, %0d budget base writes.",
             commands_sent, sb.checked, cfg_writes);
    $display("Included a backlog flood under a long result stall and budget scaling edges.");
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int   stall;
    res_t got;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = 400;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.kind      = kind_t'(kind);
      got.group_id  = group_id;
      got.drained   = drained;
      got.remaining = remaining;
      got.last      = last;
      sb.check_result(got);
    end
  end

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/fbt_pkg.sv
hw/rtl/fbt_fifo.sv
hw/rtl/fbt_front.sv
hw/rtl/fbt_back.sv
hw/rtl/frame_budget_throttle_with_backlog.sv
verif/fbt_tb_pkg.sv
verif/tb.sv
